// ===== rtl/core/fbm_pkg.sv =====
// Package: shared types, constants and controller states for the flash block map.
`default_nettype none
package fbm_pkg;
  localparam int Files       = 16;
  localparam int FileBits    = 4;
  localparam int MapEntries  = 1024;
  localparam int IdxBits     = 10;
  localparam int CountBits   = 11;
  localparam int EraseSlots  = 4;
  localparam int SlotBits    = 2;
  localparam int PoolDepth   = 32;
  localparam int PoolBits    = 5;
  localparam int FillBits    = 6;
  localparam int IdBits      = 19;

  localparam logic [1:0] ActTick   = 2'd0;
  localparam logic [1:0] ActResult = 2'd1;
  localparam logic [1:0] ActMap    = 2'd2;
  localparam logic [1:0] ActClear  = 2'd3;

  localparam logic [2:0] StMapped   = 3'd0;
  localparam logic [2:0] StUnmapped = 3'd1;
  localparam logic [2:0] StWait     = 3'd2;
  localparam logic [2:0] StIssued   = 3'd3;
  localparam logic [2:0] StIdle     = 3'd4;
  localparam logic [2:0] StRecorded = 3'd5;
  localparam logic [2:0] StCleared  = 3'd6;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  file;
    logic [17:0] logical_page;
    logic        allocate;
    logic [1:0]  slot;
    logic        erase_ok;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  phys_bus;
    logic [2:0]  phys_chip;
    logic [11:0] phys_block;
    logic [7:0]  phys_page;
    logic [18:0] erase_block_id;
    logic [1:0]  erase_slot;
    logic [5:0]  pool_level;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_FILL, S_LOOK, S_READ, S_DONE
  } state_t;

  // Controller commands to datapath
  typedef struct packed {
    logic load;      // capture request
    logic exec;      // do tick / result / clear / map checks
    logic fill_step; // move one pool entry into the map
    logic look;      // issue map read
    logic finish;    // emit result (mapped when use_map)
    logic use_map;
    logic [2:0] status;
  } cmd_t;

  // Datapath status to controller
  typedef struct packed {
    logic [1:0] action;
    logic       in_range;
    logic       allocate;
    logic       need_fill; // count <= idx
    logic       pool_empty;
  } sts_t;
endpackage
`default_nettype wire

// ===== rtl/core/fbm_ctrl.sv =====
// Controller state machine for the flash block map.
`default_nettype none
module fbm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire fbm_pkg::sts_t  sts,
  output fbm_pkg::cmd_t       cmd
);
  fbm_pkg::state_t state, state_next;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) state <= fbm_pkg::S_IDLE;
    else state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      fbm_pkg::S_IDLE: if (start) state_next = fbm_pkg::S_EXEC;
      fbm_pkg::S_EXEC: begin
        if (sts.action == fbm_pkg::ActMap && sts.in_range) begin
          if (sts.allocate) state_next = fbm_pkg::S_FILL;
          else state_next = fbm_pkg::S_LOOK;
        end else state_next = fbm_pkg::S_IDLE;
      end
      fbm_pkg::S_FILL: begin
        if (!sts.need_fill) state_next = fbm_pkg::S_LOOK;
        else if (sts.pool_empty) state_next = fbm_pkg::S_IDLE;
      end
      fbm_pkg::S_LOOK: begin
        if (sts.need_fill) state_next = fbm_pkg::S_IDLE;
        else state_next = fbm_pkg::S_READ;
      end
      fbm_pkg::S_READ: state_next = fbm_pkg::S_DONE;
      fbm_pkg::S_DONE: state_next = fbm_pkg::S_IDLE;
      default: state_next = fbm_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd = '0;
    busy = (state != fbm_pkg::S_IDLE);
    unique case (state)
      fbm_pkg::S_IDLE: cmd.load = start;
      fbm_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.action == fbm_pkg::ActMap) begin
          if (!sts.in_range) begin
            cmd.finish = 1'b1;
            cmd.status = fbm_pkg::StUnmapped;
          end
        end else begin
          cmd.finish = 1'b1;
          cmd.status = fbm_pkg::StIdle; // datapath resolves tick/result/clear
        end
      end
      fbm_pkg::S_FILL: begin
        if (sts.need_fill) begin
          if (sts.pool_empty) begin
            cmd.finish = 1'b1;
            cmd.status = fbm_pkg::StWait;
          end else cmd.fill_step = 1'b1;
        end
      end
      fbm_pkg::S_LOOK: begin
        if (sts.need_fill) begin
          cmd.finish = 1'b1;
          cmd.status = fbm_pkg::StUnmapped;
        end else cmd.look = 1'b1;
      end
      fbm_pkg::S_READ: ;
      fbm_pkg::S_DONE: begin
        cmd.finish = 1'b1;
        cmd.use_map = 1'b1;
        cmd.status = fbm_pkg::StMapped;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/core/fbm_data.sv =====
// Datapath: map memory, erased pool, erase slots and counters.
`default_nettype none
module fbm_data (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire fbm_pkg::req_t req,
  input  wire fbm_pkg::cmd_t cmd,
  input  wire logic [4:0]    threshold,
  input  wire logic          start_wr,
  input  wire logic [18:0]   start_val,
  output fbm_pkg::sts_t      sts,
  output logic               done,
  output fbm_pkg::rsp_t      rsp
);
  fbm_pkg::req_t r;
  logic [18:0] block_map [fbm_pkg::Files*fbm_pkg::MapEntries];
  logic [18:0] erased_pool [fbm_pkg::PoolDepth];
  logic [fbm_pkg::CountBits-1:0] map_count [fbm_pkg::Files];
  logic [fbm_pkg::PoolBits-1:0] pool_head;
  logic [fbm_pkg::FillBits-1:0] pool_fill;
  logic [fbm_pkg::EraseSlots-1:0] slot_busy;
  logic [18:0] slot_block [fbm_pkg::EraseSlots];
  logic [18:0] next_erase;
  logic [18:0] pool_rd, map_rd;
  logic [fbm_pkg::IdxBits-1:0] idx;
  logic [fbm_pkg::CountBits-1:0] cnt;
  logic        free_found;
  logic [fbm_pkg::SlotBits-1:0] free_slot;
  logic        issue;
  logic        push;

  // Index from page bits 17:14 and the low page bits 5:0
  assign idx = {r.logical_page[17:14], r.logical_page[5:0]};
  assign cnt = map_count[r.file];

  assign sts.action     = r.action;
  assign sts.in_range   = 1'b1;
  assign sts.allocate   = r.allocate;
  assign sts.need_fill  = (cnt <= {1'b0, idx});
  assign sts.pool_empty = (pool_fill == '0);

  // Find lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int s = fbm_pkg::EraseSlots - 1; s >= 0; s--) begin
      if (!slot_busy[s]) begin
        free_found = 1'b1;
        free_slot  = fbm_pkg::SlotBits'(s);
      end
    end
  end

  assign issue = cmd.exec && r.action == fbm_pkg::ActTick &&
                 ({1'b0, pool_fill} < {2'b0, threshold}) && free_found;
  assign push  = cmd.exec && r.action == fbm_pkg::ActResult && slot_busy[r.slot] &&
                 r.erase_ok && (pool_fill < fbm_pkg::FillBits'(fbm_pkg::PoolDepth));

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_head  <= '0;
      pool_fill  <= '0;
      slot_busy  <= '0;
      next_erase <= '0;
      for (int f = 0; f < fbm_pkg::Files; f++) map_count[f] <= '0;
    end else begin
      if (start_wr) next_erase <= start_val;
      if (issue) begin
        slot_busy[free_slot] <= 1'b1;
        next_erase <= next_erase + 19'd1;
      end
      if (cmd.exec && r.action == fbm_pkg::ActResult) slot_busy[r.slot] <= 1'b0;
      if (push) pool_fill <= pool_fill + 6'd1;
      if (cmd.exec && r.action == fbm_pkg::ActClear) map_count[r.file] <= '0;
      if (cmd.fill_step) begin
        pool_head <= pool_head + 5'd1;
        pool_fill <= pool_fill - 6'd1;
        map_count[r.file] <= cnt + 11'd1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) r <= req;
    if (issue) slot_block[free_slot] <= next_erase;
  end

  // Pool memory
  always_ff @(posedge clk) begin
    if (push) erased_pool[pool_head + pool_fill[4:0]] <= slot_block[r.slot];
  end
  assign pool_rd = erased_pool[pool_head];

  // Map memory: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.fill_step) block_map[{r.file, cnt[fbm_pkg::IdxBits-1:0]}] <= pool_rd;
    if (cmd.look) map_rd <= block_map[{r.file, idx}];
  end

  // Result
  always_comb begin
    done = cmd.finish;
    rsp  = '0;
    rsp.status = cmd.status;
    if (cmd.exec) begin
      unique case (r.action)
        fbm_pkg::ActTick:   rsp.status = issue ? fbm_pkg::StIssued : fbm_pkg::StIdle;
        fbm_pkg::ActResult: rsp.status = fbm_pkg::StRecorded;
        fbm_pkg::ActClear:  rsp.status = fbm_pkg::StCleared;
        default:            rsp.status = cmd.status;
      endcase
    end
    if (issue) begin
      rsp.erase_block_id = next_erase;
      rsp.erase_slot     = free_slot;
    end
    if (cmd.use_map) begin
      rsp.phys_bus   = map_rd[3:0];
      rsp.phys_chip  = map_rd[6:4];
      rsp.phys_block = map_rd[18:7];
      rsp.phys_page  = r.logical_page[13:6];
    end
    rsp.pool_level = push ? pool_fill + 6'd1 : pool_fill;
  end
endmodule
`default_nettype wire

// ===== rtl/core/flash_block_map_erase_pool.sv =====
// Top level: flash block map with erased-block pool, erase slots and APB registers.
`default_nettype none
// An item is taken when start is high and busy low. Its single result appears
// for one cycle with done high and cannot be stalled. Tick, erase result and
// clear go through capture, then execute. A lookup without allocate goes
// through capture, check, length test and map read, read wait, output. If the
// index is not yet filled, it ends as unmapped at the length test. With allocate,
// a fill stage sits between check and length test. It moves one map entry from
// the pool at a time until the index is covered, and then goes on to the length
// test. If the pool runs dry, the fill stage ends with the result wait. The
// map memory takes one write per cycle, so entries are filled one at a time.
module flash_block_map_erase_pool (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire fbm_pkg::req_t req,
  output logic               done,
  output fbm_pkg::rsp_t      rsp,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  fbm_pkg::cmd_t cmd;
  fbm_pkg::sts_t sts;
  logic [4:0]  prepare_threshold;
  logic [18:0] start_block;
  logic        wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      prepare_threshold <= 5'd16;
      start_block <= '0;
    end else if (wr && paddr == 3'd0) prepare_threshold <= pwdata[4:0];
    else if (wr && paddr == 3'd4) start_block <= pwdata[18:0];
  end

  always_comb begin
    prdata = '0;
    if (paddr == 3'd0) prdata = {27'd0, prepare_threshold};
    else if (paddr == 3'd4) prdata = {13'd0, start_block};
  end

  fbm_ctrl u_ctrl (.clk, .rst, .start, .busy, .sts, .cmd);

  fbm_data u_data (
    .clk, .rst, .req, .cmd,
    .threshold(prepare_threshold),
    .start_wr(wr && paddr == 3'd4),
    .start_val(pwdata[18:0]),
    .sts, .done, .rsp
  );

  // Checks
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result without a transaction");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("transaction not taken");
  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.pool_level <= 6'd32) else $error("pool overflow");
endmodule
`default_nettype wire
